>>> rtl/efc_pkg.sv
// shared constants, codes and types for the fuse controller register block
// no dependencies; imported by efc_fuse_mem, efuse_controller_registers_core and the testbench
package efc_pkg;

    localparam int FUSE_WORDS = 64;
    localparam int ADDR_BITS  = 6;
    localparam int FUSE_IDX_W = (FUSE_WORDS > 1) ? $clog2(FUSE_WORDS) : 1;
    localparam int DATA_W     = 32;
    localparam int BIT_IDX_W  = 5;

    typedef logic [FUSE_IDX_W-1:0] t_fuse_idx;
    typedef logic [DATA_W-1:0]     t_word;

    // bus operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register slots (byte offset / 4)
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_ADDR  = 2'd1;
    localparam logic [1:0] REG_NONE  = 2'd2;
    localparam logic [1:0] REG_RDATA = 2'd3;

    // mode command codes
    localparam logic [1:0] CMD_IDLE = 2'd0;
    localparam logic [1:0] CMD_UNDEF = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_BURN = 2'd3;

    // request from the controller to the fuse memory
    typedef struct packed {
        logic      rd_en;
        logic      wr_en;
        t_fuse_idx addr;
        t_word     wdata;
    } t_mem_req;

endpackage

>>> rtl/efc_fuse_mem.sv
// fuse word store: single-port synchronous memory with registered read data
// per-word valid bits make unwritten words read as zero after reset; uses efc_pkg
module efc_fuse_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  efc_pkg::t_mem_req i_req,
    output efc_pkg::t_word    o_rdata
);
    import efc_pkg::*;

    t_word                 r_mem [FUSE_WORDS];
    logic [FUSE_WORDS-1:0] r_valid;
    t_word                 r_rdata;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.addr];
            end
            if (i_req.wr_en) begin
                r_valid[i_req.addr] <= 1'b1;
            end
        end
    end

    // unprogrammed words read as zero
    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

>>> rtl/efuse_controller_registers_core.sv
// top level of the one-time-programmable fuse controller register block
// depends on efc_pkg and efc_fuse_mem
//
// Register view of a fuse controller: every input transfer is one bus access
// (read or write) to the mode, address or read-data register, and every
// access returns exactly one output transfer (register contents on reads,
// zero on writes and on the unmapped slot). The address register keeps a
// word index in its low ADDR_BITS bits and a bit index in the five bits
// above. Writing mode with command 3 sets the addressed fuse bit, command 2
// copies the addressed word into read-data, commands 0 and 1 do nothing;
// the two command bits always read back as zero. A mode write that reads or
// burns an in-range fuse word also passes through the command state, where
// the single-port fuse memory, having read the word when the write is
// accepted, hands it to read-data or writes back the burned word; all other
// accesses stay in idle. The fuse store is cleared by per-word
// valid bits at reset, so no clearing pass is needed and the block accepts
// transfers from the first cycle after reset. A result waiting in the output
// register holds off the next transfer until the result itself is taken.
module efuse_controller_registers_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [1:0]            i_reg_index,
    input  logic [31:0]           i_write_data,
    // response channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_read_data
);
    import efc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_CMD
    } t_state;

    t_state r_state;

    // architectural registers
    t_word r_mode;
    t_word r_address;
    t_word r_read_data;

    // output register
    logic  r_out_valid;
    t_word r_out_data;

    // pending fuse command, held for the command state
    logic                 r_burn;
    t_fuse_idx            r_word;
    logic [BIT_IDX_W-1:0] r_bit;

    logic                 in_accept;
    logic [ADDR_BITS-1:0] cur_word;
    logic [BIT_IDX_W-1:0] cur_bit;
    logic                 word_inside;
    logic [1:0]           cmd;
    logic                 mode_write;
    logic                 fuse_cmd;
    t_mem_req             mem_req;
    t_word                mem_rdata;
    t_word                read_mux;

    // one transfer in flight at a time; output slot must be free or draining
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept  = i_in_valid && o_in_ready;

    // address decode from the stored address register
    assign cur_word    = r_address[ADDR_BITS-1:0];
    assign cur_bit     = r_address[ADDR_BITS +: BIT_IDX_W];
    assign word_inside = int'(cur_word) < FUSE_WORDS;

    assign cmd        = i_write_data[1:0];
    assign mode_write = (i_op == OP_WRITE) && (i_reg_index == REG_MODE);
    // a read or burn command on a word that exists needs the memory
    assign fuse_cmd   = mode_write && word_inside &&
                        ((cmd == CMD_READ) || (cmd == CMD_BURN));

    // memory access: read at accept, write back the burned word next cycle
    always_comb begin
        mem_req.rd_en = in_accept && fuse_cmd;
        mem_req.wr_en = (r_state == ST_CMD) && r_burn;
        mem_req.addr  = (r_state == ST_CMD) ? r_word : FUSE_IDX_W'(cur_word);
        mem_req.wdata = mem_rdata | (t_word'(1) << r_bit);
    end

    efc_fuse_mem u_fuse_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // register read selection
    always_comb begin
        case (i_reg_index)
            REG_MODE:  read_mux = r_mode;
            REG_ADDR:  read_mux = r_address;
            REG_RDATA: read_mux = r_read_data;
            REG_NONE:  read_mux = '0;
            default:   read_mux = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= '0;
            r_address   <= '0;
            r_read_data <= '0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_burn      <= 1'b0;
            r_word      <= '0;
            r_bit       <= '0;
        end else begin
            // response leaves on a completed output transfer, unless refilled
            if (r_out_valid && i_out_ready && !in_accept) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        // result is known at once: reads return data, writes zero
                        r_out_valid <= 1'b1;
                        r_out_data  <= (i_op == OP_READ) ? read_mux : '0;

                        if (i_op == OP_WRITE) begin
                            case (i_reg_index)
                                REG_MODE: begin
                                    // command bits never stick
                                    r_mode <= {i_write_data[DATA_W-1:2], CMD_IDLE};
                                    if (fuse_cmd) begin
                                        r_state <= ST_CMD;
                                        r_burn  <= (cmd == CMD_BURN);
                                        r_word  <= FUSE_IDX_W'(cur_word);
                                        r_bit   <= cur_bit;
                                    end else if (cmd == CMD_READ) begin
                                        // word past the store reads as zero
                                        r_read_data <= '0;
                                    end
                                end
                                REG_ADDR: r_address <= i_write_data;
                                default: ;
                            endcase
                        end
                    end
                end
                ST_CMD: begin
                    // memory data is valid now; burn writes back via mem_req
                    if (!r_burn) begin
                        r_read_data <= mem_rdata;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    // no new transfer while a fuse command is finishing
    a_no_accept_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMD) |-> !o_in_ready)
        else $error("transfer accepted during fuse command");

    // a burn write-back always follows the read of the same command
    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> $past(mem_req.rd_en))
        else $error("fuse write without preceding read");

    // the command phase is always left for idle in the next cycle
    a_cmd_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMD) |=> (r_state == ST_IDLE))
        else $error("fuse command phase overran");

    // every accepted transfer produces a response in the next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted transfer produced no response");

endmodule

>>> sim/testbench.sv
// self-checking testbench for the fuse controller register block
// depends on efc_pkg and efuse_controller_registers_core from the rtl folder
`timescale 1ns / 100ps

module testbench;
    import efc_pkg::*;

    // stall patterns of the response side, switched by bits 9:8 of the cycle counter
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_RARE_STALL,
        RX_LONG_STALL
    } t_rx_pattern;

    localparam int RANDOM_ACCESSES = 1500;
    localparam int SETTLE_CYCLES   = 20;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_op         = OP_READ;
    logic [1:0]  i_reg_index  = REG_MODE;
    logic [31:0] i_write_data = '0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_read_data;

    efuse_controller_registers_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data)
    );

    // shadow copy of the register file and the fuse store
    t_word fuse_shadow [FUSE_WORDS] = '{default: '0};
    t_word mode_shadow  = '0;
    t_word addr_shadow  = '0;
    t_word rdata_shadow = '0;

    // read data awaited from the block, oldest first
    t_word pending_rdata [$];

    int n_sent       = 0;
    int n_checked    = 0;
    int n_burns      = 0;
    int n_fuse_reads = 0;
    int n_errors     = 0;
    int burst_left   = 0;

    int          rx_cycle   = 0;
    int          stall_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("timeout with %0d results still awaited", pending_rdata.size());
        $display("[efuse_controller_registers_core] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("%0t: %s: got 0x%08h, want 0x%08h", $time, what, got, want);
        n_errors++;
    endtask

    // applies one bus access to the shadow state and returns the read data it yields
    function automatic t_word predict_access(input logic op, input logic [1:0] idx,
                                             input t_word data);
        t_word                  result;
        logic [ADDR_BITS-1:0]   word;
        logic [BIT_IDX_W-1:0]   bit_idx;
        result  = '0;
        word    = addr_shadow[ADDR_BITS-1:0];
        bit_idx = addr_shadow[ADDR_BITS +: BIT_IDX_W];
        if (op == OP_READ) begin
            case (idx)
                REG_MODE:  result = mode_shadow;
                REG_ADDR:  result = addr_shadow;
                REG_RDATA: result = rdata_shadow;
                default:   result = '0;
            endcase
        end else begin
            case (idx)
                REG_MODE: begin
                    case (data[1:0])
                        CMD_BURN: begin
                            n_burns++;
                            if (word < FUSE_WORDS) fuse_shadow[word][bit_idx] = 1'b1;
                        end
                        CMD_READ: begin
                            n_fuse_reads++;
                            rdata_shadow = (word < FUSE_WORDS) ? fuse_shadow[word] : '0;
                        end
                        default: ;
                    endcase
                    // command bits always read back as idle (zero)
                    mode_shadow = {data[DATA_W-1:2], CMD_IDLE};
                end
                REG_ADDR: addr_shadow = data;
                default: ;
            endcase
        end
        return result;
    endfunction

    // response check first, then the new request, so that a result and a
    // request transferred on the same edge stay in order
    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_rdata.size() == 0) begin
                    report_mismatch("result with no access pending", o_read_data, '0);
                end else begin
                    want = pending_rdata.pop_front();
                    n_checked++;
                    if (o_read_data !== want) report_mismatch("read_data", o_read_data, want);
                end
            end
            if (i_in_valid && o_in_ready)
                pending_rdata.push_back(predict_access(i_op, i_reg_index, i_write_data));
        end
    end

    // response side back-pressure
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case (t_rx_pattern'(rx_cycle[9:8]))
            RX_OPEN:       i_out_ready <= 1'b1;
            RX_COIN:       i_out_ready <= 1'($urandom_range(0, 1));
            RX_RARE_STALL: i_out_ready <= ($urandom_range(0, 7) != 0);
            default: begin
                if (stall_left != 0) begin
                    stall_left  <= stall_left - 1;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 12);
                end
            end
        endcase
    end

    // one request transfer; valid stays high into the next access of a burst
    task automatic send_access(input logic op, input logic [1:0] idx, input t_word data);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            // now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk) i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_op         <= op;
        i_reg_index  <= idx;
        i_write_data <= data;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    // hold off the request side until every awaited result is back
    task automatic wait_for_drain();
        @(negedge i_clk) i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_rdata.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_word fuse_address(input int word, input int bit_idx, input t_word upper);
        t_word a;
        a = upper;
        a[ADDR_BITS-1:0]          = word[ADDR_BITS-1:0];
        a[ADDR_BITS +: BIT_IDX_W] = bit_idx[BIT_IDX_W-1:0];
        return a;
    endfunction

    function automatic t_word mode_word(input logic [1:0] cmd);
        t_word m;
        m      = $urandom();
        m[1:0] = cmd;
        return m;
    endfunction

    task automatic test_reset_values();
        send_access(OP_READ, REG_MODE, '0);
        send_access(OP_READ, REG_ADDR, '0);
        send_access(OP_READ, REG_NONE, '0);
        send_access(OP_READ, REG_RDATA, '0);
    endtask

    task automatic test_register_access();
        // address keeps every bit, even those above the bit index
        send_access(OP_WRITE, REG_ADDR, '1);
        send_access(OP_READ, REG_ADDR, '0);
        send_access(OP_WRITE, REG_ADDR, '0);
        send_access(OP_READ, REG_ADDR, '1);
        // mode keeps its upper bits; idle and undefined commands do nothing
        send_access(OP_WRITE, REG_MODE, {30'h3fff_ffff, CMD_IDLE});
        send_access(OP_WRITE, REG_MODE, {30'h2aaa_aaaa, CMD_UNDEF});
        send_access(OP_READ, REG_MODE, '0);
        // unmapped slot and read-data writes are dropped
        send_access(OP_WRITE, REG_NONE, '1);
        send_access(OP_READ, REG_NONE, '0);
        send_access(OP_WRITE, REG_RDATA, '1);
        send_access(OP_READ, REG_RDATA, '0);
    endtask

    task automatic test_fuse_commands();
        // all-ones address: last word, top bit
        send_access(OP_WRITE, REG_ADDR, '1);
        send_access(OP_WRITE, REG_MODE, {30'h0, CMD_BURN});
        send_access(OP_WRITE, REG_MODE, {30'h0, CMD_READ});
        send_access(OP_READ, REG_RDATA, '0);
        // first word, bit zero, burned twice
        send_access(OP_WRITE, REG_ADDR, fuse_address(0, 0, '0));
        send_access(OP_WRITE, REG_MODE, {30'h0, CMD_BURN});
        send_access(OP_WRITE, REG_MODE, {30'h1555_5555, CMD_BURN});
        send_access(OP_WRITE, REG_MODE, {30'h0, CMD_READ});
        send_access(OP_READ, REG_RDATA, '0);
        // idle command leaves read-data alone
        send_access(OP_WRITE, REG_ADDR, '1);
        send_access(OP_WRITE, REG_MODE, {30'h0, CMD_IDLE});
        send_access(OP_READ, REG_RDATA, '0);
        send_access(OP_READ, REG_MODE, '0);
    endtask

    // mostly address/command/read-back sequences on a few hot words, plus raw noise
    task automatic test_random_traffic(input int count);
        int          target;
        int          word;
        logic [1:0]  cmd;
        int          pick;
        logic        paused;
        target = n_sent + count;
        paused = 1'b0;
        while (n_sent < target) begin
            if (!paused && n_sent >= target - count / 2) begin
                wait_for_drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                word = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                            : $urandom_range(0, FUSE_WORDS - 1);
                send_access(OP_WRITE, REG_ADDR,
                            fuse_address(word, $urandom_range(0, 31), $urandom()));
                pick = $urandom_range(0, 19);
                if (pick < 10)      cmd = CMD_BURN;
                else if (pick < 17) cmd = CMD_READ;
                else if (pick < 19) cmd = CMD_IDLE;
                else                cmd = CMD_UNDEF;
                send_access(OP_WRITE, REG_MODE, mode_word(cmd));
                if (cmd == CMD_READ || $urandom_range(0, 3) == 0)
                    send_access(OP_READ, REG_RDATA, $urandom());
                if ($urandom_range(0, 4) == 0)
                    send_access(OP_READ, 2'($urandom_range(0, 3)), $urandom());
            end else begin
                send_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom());
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_register_access();
        wait_for_drain();
        test_fuse_commands();
        test_random_traffic(RANDOM_ACCESSES);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("%0d bus accesses sent, %0d results checked", n_sent, n_checked);
        $display("%0d fuse burns and %0d fuse word reads commanded", n_burns, n_fuse_reads);
        if (n_errors == 0 && pending_rdata.size() == 0) begin
            $display("[efuse_controller_registers_core] OK");
        end else begin
            $display("[efuse_controller_registers_core] ERROR");
        end
        $finish;
    end

endmodule
